>>> sv/u2c_pkg.sv
// Shared types, constants and the CP437 reverse lookup for the UTF-8 to CP437 transcoder.
// Used by u2c_decode and utf8_to_cp437_transcoder; depends on nothing else.
package u2c_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CpW      = 21;
    localparam int unsigned MapDepth = 256;

    localparam logic [ByteW-1:0] UnmappedCode = 8'h3F;

    // Sequence length minus one, as held in the decoder state.
    typedef enum logic [1:0] {
        LEN_ONE   = 2'd0,
        LEN_TWO   = 2'd1,
        LEN_THREE = 2'd2,
        LEN_FOUR  = 2'd3
    } seq_len_t;

    // One decoded beat, handed from the decoder to the output register.
    typedef struct packed {
        logic             emit;
        logic [ByteW-1:0] code;
        logic             has_char;
        logic             last;
    } result_t;

    // CP437 byte value to Unicode code point. Every entry fits in 16 bits.
    localparam logic [15:0] CP437_MAP [MapDepth] = '{
        16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25D8, 16'h25CB, 16'h000A, 16'h2642, 16'h2640, 16'h000D, 16'h266B, 16'h263C,
        16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
        16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h2302,
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A9
    };

    // Parallel compare against every entry but the first; the lowest matching
    // index wins, and a code point with no match maps to the question mark.
    function automatic logic [ByteW-1:0] cp437_lookup(input logic [CpW-1:0] cp);
        logic [ByteW-1:0] code;
        code = UnmappedCode;
        for (int j = MapDepth - 1; j >= 1; j--) begin
            if (cp[CpW-1:16] == '0 && cp[15:0] == CP437_MAP[j]) begin
                code = ByteW'(j);
            end
        end
        return code;
    endfunction

endpackage

>>> sv/u2c_decode.sv
// Strict UTF-8 decoder state and per-byte next-state logic, with the CP437 lookup.
// Depends on u2c_pkg.
module u2c_decode (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [u2c_pkg::ByteW-1:0]      byte_in,
    input  logic                           end_in,
    output u2c_pkg::result_t               res
);
    import u2c_pkg::*;

    logic [CpW-1:0] cp_reg,      cp_next;
    logic [1:0]     pending_reg, pending_next;
    seq_len_t       len_reg,     len_next;
    logic           halt_reg,    halt_next;

    logic           done;
    logic           cp_ok;
    logic [CpW-1:0] cp_work;
    logic [1:0]     pending_work;
    seq_len_t       len_work;
    logic           halt_work;

    always_comb
    begin
        cp_work      = cp_reg;
        pending_work = pending_reg;
        len_work     = len_reg;
        halt_work    = halt_reg;
        done         = 1'b0;

        if (!halt_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                if (byte_in < 8'h80)
                begin
                    cp_work  = CpW'(byte_in);
                    len_work = LEN_ONE;
                    done     = 1'b1;
                end
                else if (byte_in inside {[8'hC2:8'hDF]})
                begin
                    cp_work      = CpW'(byte_in[4:0]);
                    len_work     = LEN_TWO;
                    pending_work = 2'd1;
                end
                else if (byte_in inside {[8'hE0:8'hEF]})
                begin
                    cp_work      = CpW'(byte_in[3:0]);
                    len_work     = LEN_THREE;
                    pending_work = 2'd2;
                end
                else if (byte_in inside {[8'hF0:8'hF4]})
                begin
                    cp_work      = CpW'(byte_in[2:0]);
                    len_work     = LEN_FOUR;
                    pending_work = 2'd3;
                end
                else
                begin
                    halt_work = 1'b1;
                end
            end
            else if (byte_in[7:6] == 2'b10)
            begin
                cp_work      = {cp_reg[CpW-7:0], byte_in[5:0]};
                pending_work = pending_reg - 2'd1;
                done         = (pending_reg == 2'd1);
            end
            else
            begin
                halt_work = 1'b1;
            end
        end

        // Reject overlong forms, surrogates, values past the Unicode range and NUL.
        cp_ok = (cp_work != '0);
        case (len_work)
            LEN_TWO:   if (cp_work < 21'h80) cp_ok = 1'b0;
            LEN_THREE: if (cp_work < 21'h800 || (cp_work >= 21'hD800 && cp_work <= 21'hDFFF))
                           cp_ok = 1'b0;
            LEN_FOUR:  if (cp_work < 21'h10000 || cp_work > 21'h10FFFF) cp_ok = 1'b0;
            default:   ;
        endcase

        if (done && !cp_ok)
        begin
            halt_work = 1'b1;
            done      = 1'b0;
        end

        // The end-marked beat always closes the string and clears the state.
        if (end_in)
        begin
            cp_next      = '0;
            pending_next = 2'd0;
            len_next     = LEN_ONE;
            halt_next    = 1'b0;
        end
        else
        begin
            cp_next      = cp_work;
            pending_next = pending_work;
            len_next     = len_work;
            halt_next    = halt_work;
        end

        res.emit     = done || end_in;
        res.code     = done ? cp437_lookup(cp_work) : '0;
        res.has_char = done;
        res.last     = end_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg      <= '0;
            pending_reg <= 2'd0;
            len_reg     <= LEN_ONE;
            halt_reg    <= 1'b0;
        end
        else if (step)
        begin
            cp_reg      <= cp_next;
            pending_reg <= pending_next;
            len_reg     <= len_next;
            halt_reg    <= halt_next;
        end
    end

endmodule

>>> sv/utf8_to_cp437_transcoder.sv
// Top level of the UTF-8 to CP437 transcoder: input register, decoder, output register.
// Depends on u2c_pkg and u2c_decode.

// The block takes a UTF-8 string one byte per beat, with tlast on the final byte,
// and returns one CP437 byte for every completed code point. Decoding is strict:
// overlong forms, surrogates, values above 10FFFF, bad lead bytes, NUL and missing
// continuation bytes are errors, and after an error no characters are returned until
// the end of the string. The beat carrying tlast always gives exactly one result with
// tlast set; its tuser bit tells whether it also carries a character (tdata is zero
// when it does not). Code points with no CP437 equivalent come out as '?'. Bytes in
// the middle of a sequence give no result. Throughput is one byte per clock while the
// output is not stalled: a beat is held in the input register, where the decoder and the
// 255-way table compare produce its result, and is delivered from the output register.
// A stalled output register holds the staged byte in the input register; the
// input side then takes one more beat only while the input register is empty.
module utf8_to_cp437_transcoder (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] utf8_byte
    input  logic       s_tlast,   // end_of_string

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] cp437_code
    output logic       m_tuser,   // [0] has_char
    output logic       m_tlast    // last
);
    import u2c_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;

    logic             out_valid_reg, out_valid_next;
    logic [ByteW-1:0] out_code_reg;
    logic             out_char_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             advance;
    result_t          res;

    // The staged byte moves on once the output register can take its result.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    u2c_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .end_in  (in_last_reg),
        .res     (res)
    );

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance && res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res.emit)
        begin
            out_code_reg <= res.code;
            out_char_reg <= res.has_char;
            out_last_reg <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tuser  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/u2c_checker.sv
// Port-level checks for the UTF-8 to CP437 transcoder, bound to its top level.
// Depends on utf8_to_cp437_transcoder for the bind target only.
module u2c_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A beat without a character only closes a string.
    a_nochar_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty result beat without tlast");

    // An empty beat carries a zero byte.
    a_nochar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 8'h00)
        else $error("empty result beat with nonzero data");

    // The first table entry never matches, so a character is never zero.
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata != 8'h00)
        else $error("character beat with zero code");

endmodule

bind utf8_to_cp437_transcoder u2c_checker u_checker (.*);
